### rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, codes and controller/datapath signal groups for the
// background preempt selector.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int NUM_CPUS_DEF = 256;

  // configuration register indexes and reset values
  localparam logic [7:0]  CFG_MIN_RUN  = 8'd0;
  localparam logic [7:0]  CFG_FG_SLICE = 8'd1;
  localparam logic [7:0]  CFG_BG_SLICE = 8'd2;

  localparam logic [31:0] MIN_RUN_RST  = 32'd2000000;
  localparam logic [31:0] FG_SLICE_RST = 32'd5000000;
  localparam logic [31:0] BG_SLICE_RST = 32'd20000000;

  // event codes
  localparam logic [1:0] MODE_WAKE      = 2'd0;
  localparam logic [1:0] MODE_ENQUEUE   = 2'd1;
  localparam logic [1:0] MODE_RUN_START = 2'd2;
  localparam logic [1:0] MODE_RUN_STOP  = 2'd3;

  // queue codes
  localparam logic [1:0] Q_NONE  = 2'd0;
  localparam logic [1:0] Q_LOCAL = 2'd1;
  localparam logic [1:0] Q_FG    = 2'd2;
  localparam logic [1:0] Q_BG    = 2'd3;

  // background name prefixes
  localparam logic [31:0] PREFIX_BG4 = 32'h62696F5F;
  localparam logic [55:0] PREFIX_R7  = 56'h72656469732D72;
  localparam logic [55:0] PREFIX_A7  = 56'h72656469732D61;

  // per-cpu word: running flag above the start time
  localparam int WORD_W = 65;

  typedef struct packed {
    logic clr;       // clearing pass, one entry per cycle
    logic capture;   // take the incoming item
    logic exec;      // apply run start/stop, open the scan
    logic scan;      // compare one entry
    logic load_out;  // move result to the output register
  } bps_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic need_scan;
    logic hit;
  } bps_sts_t;

endpackage

### rtl/bps_in_if.sv
// ----------------------------------------------------------------------------
// bps_in_if
// Scheduler event channel.
// ----------------------------------------------------------------------------
interface bps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  cpu_id;
  logic [55:0] name_prefix;
  logic        name_ok;
  logic        idle_found;
  logic [63:0] now_ns;

  modport source (
    output valid, mode, cpu_id, name_prefix, name_ok, idle_found, now_ns,
    input  ready
  );
  modport sink (
    input  valid, mode, cpu_id, name_prefix, name_ok, idle_found, now_ns,
    output ready
  );
endinterface

### rtl/bps_out_if.sv
// ----------------------------------------------------------------------------
// bps_out_if
// Decision channel, one item per event.
// ----------------------------------------------------------------------------
interface bps_out_if;
  logic        valid;
  logic        ready;
  logic        is_background;
  logic [1:0]  queue_choice;
  logic [31:0] slice_ns;
  logic        kick_valid;
  logic [7:0]  kick_cpu;

  modport source (
    output valid, is_background, queue_choice, slice_ns, kick_valid, kick_cpu,
    input  ready
  );
  modport sink (
    input  valid, is_background, queue_choice, slice_ns, kick_valid, kick_cpu,
    output ready
  );
endinterface

### rtl/bps_cfg_if.sv
// ----------------------------------------------------------------------------
// bps_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface bps_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  idx;
  logic [31:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

### rtl/background_preempt_selector.sv
// ----------------------------------------------------------------------------
// background_preempt_selector
// Classifies scheduler events by task name, tracks per-cpu background runs
// and picks a cpu to preempt on a foreground wake.
//
//   channel | dir | handshake     | payload
//   evt     | in  | valid / ready | mode, cpu_id, name_prefix, name_ok,
//           |     |               | idle_found, now_ns
//   res     | out | valid / ready | is_background, queue_choice, slice_ns,
//           |     |               | kick_valid, kick_cpu
//   cfg     | in  | valid / ready | idx, wdata (always ready)
//
// one item at a time; enqueue, run start/stop and idle wakes go from accept
// through exec to the result register; a foreground wake with no idle cpu
// also scans the single-port per-cpu store one entry a cycle to a hit or end
// after reset a clearing pass zeroes all NUM_CPUS entries before the first item
// a held result does not block the next accept; only its hand-off waits
// ----------------------------------------------------------------------------
module background_preempt_selector #(
  parameter int NUM_CPUS = bps_pkg::NUM_CPUS_DEF
) (
  input logic       clk,
  input logic       rst,
  bps_in_if.sink    evt,
  bps_out_if.source res,
  bps_cfg_if.sink   cfg
);
  import bps_pkg::*;

  bps_cmd_t cmd;
  bps_sts_t sts;

  assign cfg.ready = 1'b1;

  bps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (evt.valid),
    .in_ready  (evt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bps_dp #(
    .NUM_CPUS (NUM_CPUS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg.valid),
    .cfg_idx       (cfg.idx),
    .cfg_wdata     (cfg.wdata),
    .mode          (evt.mode),
    .cpu_id        (evt.cpu_id),
    .name_prefix   (evt.name_prefix),
    .name_ok       (evt.name_ok),
    .idle_found    (evt.idle_found),
    .now_ns        (evt.now_ns),
    .is_background (res.is_background),
    .queue_choice  (res.queue_choice),
    .slice_ns      (res.slice_ns),
    .kick_valid    (res.kick_valid),
    .kick_cpu      (res.kick_cpu)
  );

endmodule

### rtl/bps_ram.sv
// ----------------------------------------------------------------------------
// bps_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/bps_ctrl.sv
// ----------------------------------------------------------------------------
// bps_ctrl
// Sequencer: clearing pass, item capture, cpu scan and result hand-off.
// ----------------------------------------------------------------------------
module bps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bps_pkg::bps_sts_t sts,
  output bps_pkg::bps_cmd_t cmd
);
  import bps_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.cnt_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("reset did not start the clearing pass");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_EXEC)
    else $error("accepted item not executed");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken item");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.cnt_last) |=> state == S_FIN)
    else $error("scan ran past the last cpu");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not offered");

endmodule

### rtl/bps_dp.sv
// ----------------------------------------------------------------------------
// bps_dp
// Datapath: config registers, captured event, per-cpu store, elapsed-time
// compare and result registers.
// ----------------------------------------------------------------------------
module bps_dp #(
  parameter int NUM_CPUS = bps_pkg::NUM_CPUS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bps_pkg::bps_cmd_t cmd,
  output bps_pkg::bps_sts_t sts,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  input  logic [1:0]        mode,
  input  logic [7:0]        cpu_id,
  input  logic [55:0]       name_prefix,
  input  logic              name_ok,
  input  logic              idle_found,
  input  logic [63:0]       now_ns,
  output logic              is_background,
  output logic [1:0]        queue_choice,
  output logic [31:0]       slice_ns,
  output logic              kick_valid,
  output logic [7:0]        kick_cpu
);
  import bps_pkg::*;

  localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  logic [31:0] min_run;
  logic [31:0] fg_slice;
  logic [31:0] bg_slice;

  // captured event
  logic [1:0]    mode_r;
  logic          bg_r;
  logic          idle_r;
  logic          in_range_r;
  logic [AW-1:0] cpu_addr_r;
  logic [63:0]   now_r;

  logic            bg_in;
  logic [AW+7:0]   cpu_ext;
  logic [AW-1:0]   cnt;
  logic [AW-1:0]   cnt_plus1;
  logic [AW+7:0]   cnt_ext;
  logic            run_op;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [63:0]     elapsed;

  logic        kv_r;
  logic [7:0]  kc_r;
  logic [1:0]  queue_res;
  logic [31:0] slice_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run  <= MIN_RUN_RST;
      fg_slice <= FG_SLICE_RST;
      bg_slice <= BG_SLICE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_RUN:  min_run  <= cfg_wdata;
        CFG_FG_SLICE: fg_slice <= cfg_wdata;
        CFG_BG_SLICE: bg_slice <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a name that could not be read is foreground
  assign bg_in = name_ok && ((name_prefix[55:24] == PREFIX_BG4) ||
                             (name_prefix == PREFIX_R7) ||
                             (name_prefix == PREFIX_A7));
  assign cpu_ext = {{AW{1'b0}}, cpu_id};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= mode;
      bg_r       <= bg_in;
      idle_r     <= idle_found;
      in_range_r <= (32'(cpu_id) < 32'(NUM_CPUS));
      cpu_addr_r <= cpu_ext[AW-1:0];
      now_r      <= now_ns;
    end
  end

  assign cnt_plus1     = cnt + 1'b1;
  assign cnt_ext       = {8'd0, cnt};
  assign sts.cnt_last  = (cnt == AW'(NUM_CPUS - 1));
  assign sts.need_scan = (mode_r == MODE_WAKE) && !idle_r && !bg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clr) begin
      cnt <= sts.cnt_last ? '0 : cnt_plus1;
    end else if (cmd.exec) begin
      cnt <= '0;
    end else if (cmd.scan) begin
      cnt <= cnt_plus1;
    end
  end

  assign run_op = ((mode_r == MODE_RUN_START) || (mode_r == MODE_RUN_STOP)) &&
                  bg_r && in_range_r;
  assign ram_we = cmd.clr || (cmd.exec && run_op);

  // exec opens the scan at entry zero; during the scan the next entry is read
  always_comb begin
    if (cmd.clr) begin
      ram_addr = cnt;
    end else if (cmd.exec) begin
      ram_addr = run_op ? cpu_addr_r : '0;
    end else begin
      ram_addr = cnt_plus1;
    end
  end

  assign ram_wdata = cmd.clr ? '0 : {(mode_r == MODE_RUN_START), now_r};

  bps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_CPUS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // elapsed time wraps at 64 bits
  assign elapsed = now_r - ram_rdata[63:0];
  assign sts.hit = ram_rdata[WORD_W-1] && (elapsed >= {32'd0, min_run});

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kv_r <= 1'b0;
      kc_r <= '0;
    end else if (cmd.scan && sts.hit) begin
      kv_r <= 1'b1;
      kc_r <= cnt_ext[7:0];
    end
  end

  always_comb begin
    queue_res = Q_NONE;
    slice_res = '0;
    case (mode_r)
      MODE_WAKE: begin
        if (idle_r) begin
          queue_res = Q_LOCAL;
          slice_res = bg_r ? bg_slice : fg_slice;
        end
      end
      MODE_ENQUEUE: begin
        queue_res = bg_r ? Q_BG : Q_FG;
        slice_res = bg_r ? bg_slice : fg_slice;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      is_background <= bg_r;
      queue_choice  <= queue_res;
      slice_ns      <= slice_res;
      kick_valid    <= kv_r;
      kick_cpu      <= kc_r;
    end
  end

endmodule

### test/background_preempt_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_preempt_selector_tb
// Self-checking bench for the background preempt selector. Scheduler events
// go in through the event channel, and each one is run through a local
// model of the classifier, the per-cpu run table and the preempt scan.
// Every decision that comes out is compared against the oldest prediction.
// Directed cases come first, then register sweeps, random traffic,
// back-pressure, drain pauses and an unthrottled stream.
// ----------------------------------------------------------------------------
module background_preempt_selector_tb;
  import bps_pkg::*;

  localparam int          STALL_LIMIT = 20000;
  localparam int          LONG_HOLD   = 400;
  localparam logic [7:0]  CFG_NONE    = 8'd3;
  localparam logic [7:0]  CFG_FAR     = 8'hFF;

  localparam logic [55:0] NAME_KWORKER  = 56'h6b776f726b6572;
  localparam logic [55:0] NAME_BIO      = {PREFIX_BG4, 24'h736574};
  localparam logic [55:0] NAME_R7_MISS  = {PREFIX_R7[55:8], 8'h78};
  localparam logic [55:0] NAME_BIO_MISS = {32'h62696F60, 24'h000000};
  localparam logic [63:0] WRAP_START    = 64'hFFFF_FFFF_FFFF_FC18;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  cpu_id;
    logic [55:0] name_prefix;
    logic        name_ok;
    logic        idle_found;
    logic [63:0] now_ns;
  } sched_evt_t;

  typedef struct {
    logic        is_background;
    logic [1:0]  queue_choice;
    logic [31:0] slice_ns;
    logic        kick_valid;
    logic [7:0]  kick_cpu;
  } decision_t;

  logic clk = 1'b0;
  logic rst;

  bps_in_if  evt ();
  bps_out_if res ();
  bps_cfg_if cfg ();

  background_preempt_selector dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local model of the block
  logic [31:0] cur_min_run  = MIN_RUN_RST;
  logic [31:0] cur_fg_slice = FG_SLICE_RST;
  logic [31:0] cur_bg_slice = BG_SLICE_RST;
  logic        bg_on_cpu    [NUM_CPUS_DEF];
  logic [63:0] run_begin_ns [NUM_CPUS_DEF];

  decision_t   pending_decisions [$];
  int unsigned err_cnt     = 0;
  int unsigned idle_cycles = 0;
  logic [63:0] clock_ns    = 64'd0;
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          hold_token  = 1'b0;
  bit          hold_seen   = 1'b0;
  int          hold_left   = 0;
  int          stall_left  = 0;

  initial begin
    for (int i = 0; i < NUM_CPUS_DEF; i++) begin
      bg_on_cpu[i]    = 1'b0;
      run_begin_ns[i] = 64'd0;
    end
  end

  function automatic logic is_bg_name(input logic [55:0] prefix, input logic ok);
    if (!ok)
      return 1'b0;
    return prefix[55:24] == PREFIX_BG4 || prefix == PREFIX_R7 || prefix == PREFIX_A7;
  endfunction

  function automatic decision_t predict_decision(input sched_evt_t e);
    decision_t d;
    logic      bg;
    logic      found;
    bg              = is_bg_name(e.name_prefix, e.name_ok);
    d.is_background = bg;
    d.queue_choice  = Q_NONE;
    d.slice_ns      = 32'd0;
    d.kick_valid    = 1'b0;
    d.kick_cpu      = 8'd0;
    found           = 1'b0;
    case (e.mode)
      MODE_WAKE: begin
        if (e.idle_found) begin
          d.queue_choice = Q_LOCAL;
          d.slice_ns     = bg ? cur_bg_slice : cur_fg_slice;
        end else if (!bg) begin
          // first cpu in ascending order whose background run is old enough
          for (int i = 0; i < NUM_CPUS_DEF; i++) begin
            if (!found && bg_on_cpu[i] &&
                (e.now_ns - run_begin_ns[i]) >= {32'h0, cur_min_run}) begin
              found        = 1'b1;
              d.kick_valid = 1'b1;
              d.kick_cpu   = i[7:0];
            end
          end
        end
      end
      MODE_ENQUEUE: begin
        d.queue_choice = bg ? Q_BG : Q_FG;
        d.slice_ns     = bg ? cur_bg_slice : cur_fg_slice;
      end
      default: begin
        if (bg && int'(e.cpu_id) < NUM_CPUS_DEF) begin
          if (e.mode == MODE_RUN_START) begin
            bg_on_cpu[e.cpu_id]    = 1'b1;
            run_begin_ns[e.cpu_id] = e.now_ns;
          end else begin
            bg_on_cpu[e.cpu_id] = 1'b0;
          end
        end
      end
    endcase
    return d;
  endfunction

  function automatic sched_evt_t mk_event(input logic [1:0] mode, input logic [7:0] cpu,
                                          input logic [55:0] name, input logic ok,
                                          input logic idle, input logic [63:0] now);
    sched_evt_t e;
    e.mode        = mode;
    e.cpu_id      = cpu;
    e.name_prefix = name;
    e.name_ok     = ok;
    e.idle_found  = idle;
    e.now_ns      = now;
    return e;
  endfunction

  function automatic logic [55:0] bg_name();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 2))
      0:       return {PREFIX_BG4, r[23:0]};
      1:       return PREFIX_R7;
      default: return PREFIX_A7;
    endcase
  endfunction

  function automatic logic [55:0] fg_name();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      // near misses of the background prefixes
      0:       return {PREFIX_BG4 ^ (32'h1 << r[60:56]), r[23:0]};
      1:       return {PREFIX_R7[55:8], r[7:0]};
      default: return r[55:0];
    endcase
  endfunction

  function automatic logic [7:0] pick_cpu();
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      default: return 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [63:0] time_step();
    case ($urandom_range(0, 4))
      0:       return {32'h0, $urandom_range(0, 100)};
      1, 2:    return {32'h0, $urandom_range(0, 3000000)};
      3:       return {32'h0, cur_min_run} + {32'h0, $urandom_range(0, 2)};
      default: return {32'h0, $urandom};
    endcase
  endfunction

  function automatic sched_evt_t random_event();
    sched_evt_t e;
    int         pick;
    pick     = $urandom_range(0, 99);
    clock_ns = clock_ns + time_step();
    e = mk_event(MODE_WAKE, pick_cpu(), fg_name(), ($urandom_range(0, 9) != 0), 1'b0,
                 clock_ns);
    if (pick < 25) begin
      e.mode        = MODE_RUN_START;
      e.name_prefix = bg_name();
    end else if (pick < 40) begin
      e.mode        = MODE_RUN_STOP;
      e.name_prefix = bg_name();
    end else if (pick < 70) begin
      e.idle_found = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0)
        e.name_prefix = bg_name();
    end else if (pick < 85) begin
      e.mode = MODE_ENQUEUE;
      if ($urandom_range(0, 1) == 0)
        e.name_prefix = bg_name();
    end else begin
      // noise: every field fully random
      e = mk_event(2'($urandom), 8'($urandom), 56'({$urandom, $urandom} >> 8),
                   1'($urandom), 1'($urandom), {$urandom, $urandom});
    end
    return e;
  endfunction

  // stop offering items and wait for every decision to come back
  task automatic wait_drained();
    evt.valid <= 1'b0;
    while (pending_decisions.size() != 0)
      @(posedge clk);
  endtask

  task automatic send_event(input sched_evt_t e);
    int gap;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt.valid       <= 1'b1;
    evt.mode        <= e.mode;
    evt.cpu_id      <= e.cpu_id;
    evt.name_prefix <= e.name_prefix;
    evt.name_ok     <= e.name_ok;
    evt.idle_found  <= e.idle_found;
    evt.now_ns      <= e.now_ns;
    @(posedge clk);
    while (!evt.ready)
      @(posedge clk);
    pending_decisions.push_back(predict_decision(e));
  endtask

  // leaves cfg.valid high so that back-to-back writes need no gap
  task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.idx   <= index;
    cfg.wdata <= value;
    @(posedge clk);
    while (!cfg.ready)
      @(posedge clk);
    case (index)
      CFG_MIN_RUN:  cur_min_run  = value;
      CFG_FG_SLICE: cur_fg_slice = value;
      CFG_BG_SLICE: cur_bg_slice = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] min_run, input logic [31:0] fg_slice,
                              input logic [31:0] bg_slice);
    write_reg(CFG_MIN_RUN, min_run);
    write_reg(CFG_FG_SLICE, fg_slice);
    write_reg(CFG_BG_SLICE, bg_slice);
    cfg.valid <= 1'b0;
  endtask

  // runs on reset register values
  task automatic test_default_directed();
    send_event(mk_event(MODE_ENQUEUE, 8'd0, NAME_KWORKER, 1'b1, 1'b0, 64'd0));
    send_event(mk_event(MODE_ENQUEUE, 8'd1, NAME_BIO, 1'b1, 1'b0, 64'd0));
    send_event(mk_event(MODE_ENQUEUE, 8'd2, PREFIX_R7, 1'b1, 1'b0, 64'd0));
    send_event(mk_event(MODE_ENQUEUE, 8'd3, PREFIX_A7, 1'b1, 1'b0, 64'd0));
    // unreadable name counts as foreground
    send_event(mk_event(MODE_ENQUEUE, 8'd4, PREFIX_R7, 1'b0, 1'b1, 64'd0));
    send_event(mk_event(MODE_ENQUEUE, 8'hFF, {56{1'b1}}, 1'b1, 1'b1, {64{1'b1}}));
    send_event(mk_event(MODE_ENQUEUE, 8'd0, 56'd0, 1'b1, 1'b0, 64'd0));
    send_event(mk_event(MODE_ENQUEUE, 8'd0, NAME_R7_MISS, 1'b1, 1'b0, 64'd0));
    send_event(mk_event(MODE_ENQUEUE, 8'd0, NAME_BIO_MISS, 1'b1, 1'b0, 64'd0));
    // wakes with an idle cpu go local
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_BIO, 1'b1, 1'b1, 64'd0));
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_KWORKER, 1'b1, 1'b1, 64'd0));
    // nothing running yet, so no kick
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_KWORKER, 1'b1, 1'b0, 64'd500));
    // foreground run start leaves the table alone
    send_event(mk_event(MODE_RUN_START, 8'd5, NAME_KWORKER, 1'b1, 1'b0, 64'd1000));
    send_event(mk_event(MODE_RUN_START, 8'd255, NAME_BIO, 1'b1, 1'b0, 64'd1000));
    send_event(mk_event(MODE_RUN_START, 8'd3, PREFIX_A7, 1'b1, 1'b0, 64'd2000));
    // cpu 3 one short of the threshold, cpu 255 past it
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_KWORKER, 1'b1, 1'b0, 64'd2001999));
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_KWORKER, 1'b1, 1'b0, 64'd2002000));
    // background wake never kicks
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_BIO, 1'b1, 1'b0, 64'd2002000));
    send_event(mk_event(MODE_RUN_STOP, 8'd3, NAME_KWORKER, 1'b1, 1'b0, 64'd2002000));
    send_event(mk_event(MODE_RUN_STOP, 8'd3, PREFIX_A7, 1'b1, 1'b0, 64'd2002000));
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_KWORKER, 1'b0, 1'b0, 64'd2002000));
    // elapsed time across the 64-bit wrap
    send_event(mk_event(MODE_RUN_START, 8'd0, PREFIX_R7, 1'b1, 1'b0, WRAP_START));
    send_event(mk_event(MODE_WAKE, 8'd0, NAME_KWORKER, 1'b1, 1'b0, 64'd1999000));
    send_event(mk_event(MODE_WAKE, 8'd9, NAME_KWORKER, 1'b1, 1'b0, {64{1'b1}}));
    send_event(mk_event(MODE_RUN_STOP, 8'd255, NAME_BIO, 1'b1, 1'b0, 64'd0));
    send_event(mk_event(MODE_RUN_STOP, 8'd0, PREFIX_R7, 1'b1, 1'b0, 64'd0));
  endtask

  task automatic test_register_sweep();
    for (int s = 0; s < 4; s++) begin
      case (s)
        0:       program_regs(32'd0, 32'd0, 32'd0);
        1:       program_regs({32{1'b1}}, {32{1'b1}}, {32{1'b1}});
        2:       program_regs(32'd1, $urandom, $urandom);
        default: program_regs($urandom_range(0, 5000000), $urandom, $urandom);
      endcase
      repeat (30) send_event(random_event());
    end
    // writes past the last register are dropped
    write_reg(CFG_NONE, $urandom);
    write_reg(CFG_FAR, $urandom);
    cfg.valid <= 1'b0;
    repeat (10) send_event(random_event());
  endtask

  task automatic test_random_mix();
    program_regs($urandom_range(1000, 4000000), $urandom, $urandom);
    // start just below the wrap so elapsed times cross it
    clock_ns = 64'hFFFF_FFFF_FFF0_0000;
    repeat (400) send_event(random_event());
  endtask

  task automatic test_fill_stall();
    in_idle_on = 1'b0;
    hold_token <= ~hold_token;
    repeat (16) send_event(random_event());
    in_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 30; k++) begin
      send_event(random_event());
      if (k % 10 == 9)
        wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    program_regs(MIN_RUN_RST, FG_SLICE_RST, BG_SLICE_RST);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (150) send_event(random_event());
  endtask

  // result side: random stall bursts and one long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res.ready  <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      res.ready  <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    decision_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_decisions.size() == 0) begin
        if (err_cnt < 10)
          $display("%0t: decision with none pending: bg=%0d q=%0d slice=%0d kick=%0d/%0d",
                   $time, res.is_background, res.queue_choice, res.slice_ns,
                   res.kick_valid, res.kick_cpu);
        err_cnt <= err_cnt + 1;
      end else begin
        want = pending_decisions.pop_front();
        if (res.is_background !== want.is_background ||
            res.queue_choice  !== want.queue_choice  ||
            res.slice_ns      !== want.slice_ns      ||
            res.kick_valid    !== want.kick_valid    ||
            res.kick_cpu      !== want.kick_cpu) begin
          if (err_cnt < 10) begin
            $display("%0t: decision mismatch", $time);
            $display("  expected bg=%0d q=%0d slice=%0d kick=%0d/%0d",
                     want.is_background, want.queue_choice, want.slice_ns,
                     want.kick_valid, want.kick_cpu);
            $display("  actual   bg=%0d q=%0d slice=%0d kick=%0d/%0d",
                     res.is_background, res.queue_choice, res.slice_ns,
                     res.kick_valid, res.kick_cpu);
          end
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  // no handshake on any channel for too long
  always @(posedge clk) begin
    if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("background_preempt_selector_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    evt.valid       = 1'b0;
    evt.mode        = MODE_WAKE;
    evt.cpu_id      = 8'd0;
    evt.name_prefix = 56'd0;
    evt.name_ok     = 1'b0;
    evt.idle_found  = 1'b0;
    evt.now_ns      = 64'd0;
    cfg.valid       = 1'b0;
    cfg.idx         = CFG_MIN_RUN;
    cfg.wdata       = 32'd0;
    rst             = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_default_directed();
    test_register_sweep();
    test_random_mix();
    test_fill_stall();
    test_drain_pause();
    test_steady_stream();

    wait_drained();
    repeat (NUM_CPUS_DEF + 8) @(posedge clk);
    if (err_cnt == 0 && pending_decisions.size() == 0) begin
      $display("background_preempt_selector_tb OK");
    end else begin
      $display("background_preempt_selector_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/bps_pkg.sv
rtl/bps_in_if.sv
rtl/bps_out_if.sv
rtl/bps_cfg_if.sv
rtl/bps_ram.sv
rtl/bps_ctrl.sv
rtl/bps_dp.sv
rtl/background_preempt_selector.sv
test/background_preempt_selector_tb.sv
